// ===== rtl/core/rsqb_pkg.sv =====
// ----------------------------------------------------------------------------
// rsqb_pkg
// Shared types and constants for the rotated sprite quad builder.
// ----------------------------------------------------------------------------
package rsqb_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int QUEUE_DEPTH       = 2;
    localparam int ACC_W             = 53;

    localparam logic signed [25:0] CORDIC_GAIN = 26'sd10188014;
    localparam logic signed [27:0] POS_MAX     = 28'sd33554431;
    localparam logic signed [27:0] POS_MIN     = -28'sd33554432;

    // atan(2^-i) in 2^-32 turn units
    localparam logic signed [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    typedef enum logic [1:0] {
        CORNER_BL = 2'd0,
        CORNER_BR = 2'd1,
        CORNER_TR = 2'd2,
        CORNER_TL = 2'd3
    } t_corner;

    typedef struct packed {
        logic signed [25:0] cx;
        logic signed [25:0] cy;
        logic [23:0]        hw;
        logic [23:0]        hh;
        logic [17:0]        u0;
        logic [17:0]        u1;
        logic [17:0]        v0;
        logic [17:0]        v1;
        logic [31:0]        tint;
    } t_sprite;

    typedef struct packed {
        logic signed [25:0] cos_v;
        logic signed [25:0] sin_v;
        t_sprite            spr;
    } t_qentry;

    typedef struct packed {
        logic valid;
        logic pop;
    } t_q_handshake;

endpackage

// ===== rtl/core/rotated_sprite_quad_builder.sv =====
// ----------------------------------------------------------------------------
// rotated_sprite_quad_builder
// One sprite in, four rotated quad vertices out (BL, BR, TR, TL).
// ----------------------------------------------------------------------------
// A sprite is taken in one transfer and produces four vertex transfers. The back
// end emits them one vertex per cycle while the output is not stalled, from a
// single set of rotation products. The front end runs a fully pipelined CORDIC
// with one stage per iteration. A two-entry queue between front and back lets
// the input keep accepting while vertices wait on the output. No configuration
// and no clearing pass.
module rotated_sprite_quad_builder #(
    parameter int CORDIC_STAGES = rsqb_pkg::CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [23:0]        i_dst_x,
    input  logic [23:0]        i_dst_y,
    input  logic [23:0]        i_dst_w,
    input  logic [23:0]        i_dst_h,
    input  logic [16:0]        i_src_u,
    input  logic [16:0]        i_src_v,
    input  logic [16:0]        i_src_w,
    input  logic [16:0]        i_src_h,
    input  logic [15:0]        i_angle,
    input  logic [31:0]        i_color_rgba,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_corner,
    output logic signed [25:0] o_pos_x,
    output logic signed [25:0] o_pos_y,
    output logic [17:0]        o_tex_u,
    output logic [17:0]        o_tex_v,
    output logic [31:0]        o_tint,
    output logic               o_last
);
    import rsqb_pkg::*;

    logic         q_full, push, q_valid;
    t_qentry      push_data, q_data;
    t_q_handshake q_hs;

    rsqb_front #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_dst_x     (i_dst_x),
        .i_dst_y     (i_dst_y),
        .i_dst_w     (i_dst_w),
        .i_dst_h     (i_dst_h),
        .i_src_u     (i_src_u),
        .i_src_v     (i_src_v),
        .i_src_w     (i_src_w),
        .i_src_h     (i_src_h),
        .i_angle     (i_angle),
        .i_color_rgba(i_color_rgba),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    rsqb_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_data(push_data),
        .o_full     (q_full),
        .i_hs       (q_hs),
        .o_valid    (q_valid),
        .o_data     (q_data)
    );

    rsqb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_data (q_data),
        .o_hs     (q_hs),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_corner (o_corner),
        .o_pos_x  (o_pos_x),
        .o_pos_y  (o_pos_y),
        .o_tex_u  (o_tex_u),
        .o_tex_v  (o_tex_v),
        .o_tint   (o_tint),
        .o_last   (o_last)
    );

endmodule

// ===== rtl/core/rsqb_front.sv =====
// ----------------------------------------------------------------------------
// rsqb_front
// Sprite intake: centre and UV setup, angle fold and pipelined CORDIC.
// ----------------------------------------------------------------------------
module rsqb_front #(
    parameter int CORDIC_STAGES = rsqb_pkg::CORDIC_STAGES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [23:0]      i_dst_x,
    input  logic [23:0]      i_dst_y,
    input  logic [23:0]      i_dst_w,
    input  logic [23:0]      i_dst_h,
    input  logic [16:0]      i_src_u,
    input  logic [16:0]      i_src_v,
    input  logic [16:0]      i_src_w,
    input  logic [16:0]      i_src_h,
    input  logic [15:0]      i_angle,
    input  logic [31:0]      i_color_rgba,
    input  logic             i_q_full,
    output logic             o_push,
    output rsqb_pkg::t_qentry o_push_data
);
    import rsqb_pkg::*;

    localparam int N = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

    logic               r_vld [N+1];
    logic signed [25:0] r_x   [N+1];
    logic signed [25:0] r_y   [N+1];
    logic signed [31:0] r_z   [N+1];
    logic [1:0]         r_q   [N+1];
    t_sprite            r_spr [N+1];

    logic               advance;
    logic [15:0]        ang_sum;
    logic [1:0]         n_q0;
    logic [15:0]        resid;
    t_sprite            n_spr0;

    assign advance = !r_vld[N] || !i_q_full;
    assign o_ready = advance;
    assign o_push  = r_vld[N] && !i_q_full;

    // fold angle to nearest quadrant
    always_comb begin
        ang_sum     = i_angle + 16'h2000;
        n_q0        = ang_sum[15:14];
        resid       = i_angle - {n_q0, 14'b0};
        n_spr0.cx   = {i_dst_x[23], i_dst_x, 1'b0} + {2'b00, i_dst_w};
        n_spr0.cy   = {i_dst_y[23], i_dst_y, 1'b0} + {2'b00, i_dst_h};
        n_spr0.hw   = i_dst_w;
        n_spr0.hh   = i_dst_h;
        n_spr0.u0   = {1'b0, i_src_u};
        n_spr0.u1   = {1'b0, i_src_u} + {1'b0, i_src_w};
        n_spr0.v0   = {1'b0, i_src_v};
        n_spr0.v1   = {1'b0, i_src_v} + {1'b0, i_src_h};
        n_spr0.tint = i_color_rgba;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (advance) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_x[0]   <= CORDIC_GAIN;
            r_y[0]   <= '0;
            r_z[0]   <= {resid, 16'b0};
            r_q[0]   <= n_q0;
            r_spr[0] <= n_spr0;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic signed [25:0] n_x;
        logic signed [25:0] n_y;
        logic signed [31:0] n_z;

        always_comb begin
            if (!r_z[i][31]) begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - ATAN_TURNS[i];
            end else begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + ATAN_TURNS[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else if (advance) begin
                r_vld[i+1] <= r_vld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_x[i+1]   <= n_x;
                r_y[i+1]   <= n_y;
                r_z[i+1]   <= n_z;
                r_q[i+1]   <= r_q[i];
                r_spr[i+1] <= r_spr[i];
            end
        end
    end

    // undo quadrant fold
    always_comb begin
        o_push_data.spr = r_spr[N];
        unique case (r_q[N])
            2'd0: begin
                o_push_data.cos_v = r_x[N];
                o_push_data.sin_v = r_y[N];
            end
            2'd1: begin
                o_push_data.cos_v = -r_y[N];
                o_push_data.sin_v = r_x[N];
            end
            2'd2: begin
                o_push_data.cos_v = -r_x[N];
                o_push_data.sin_v = -r_y[N];
            end
            default: begin
                o_push_data.cos_v = r_y[N];
                o_push_data.sin_v = -r_x[N];
            end
        endcase
    end

endmodule

// ===== rtl/core/rsqb_queue.sv =====
// ----------------------------------------------------------------------------
// rsqb_queue
// Short FIFO between the CORDIC front end and the vertex back end.
// ----------------------------------------------------------------------------
module rsqb_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  rsqb_pkg::t_qentry     i_push_data,
    output logic                  o_full,
    input  rsqb_pkg::t_q_handshake i_hs,
    output logic                  o_valid,
    output rsqb_pkg::t_qentry     o_data
);
    import rsqb_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_qentry            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic               pop;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign pop     = i_hs.pop && i_hs.valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(pop);
        end
    end

endmodule

// ===== rtl/core/rsqb_back.sv =====
// ----------------------------------------------------------------------------
// rsqb_back
// Vertex generation: rotation products, four corners, rounding and clamp.
// ----------------------------------------------------------------------------
module rsqb_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  rsqb_pkg::t_qentry      i_q_data,
    output rsqb_pkg::t_q_handshake o_hs,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [1:0]             o_corner,
    output logic signed [25:0]     o_pos_x,
    output logic signed [25:0]     o_pos_y,
    output logic [17:0]            o_tex_u,
    output logic [17:0]            o_tex_v,
    output logic [31:0]            o_tint,
    output logic                   o_last
);
    import rsqb_pkg::*;

    logic                    r_m_vld;
    logic signed [50:0]      r_hwc, r_hhs, r_hws, r_hhc;
    logic signed [ACC_W-1:0] r_bx, r_by;
    logic [17:0]             r_u0, r_u1, r_v0, r_v1;
    logic [31:0]             r_tint;
    t_corner                 r_k;
    logic                    r_o_vld;

    logic                    out_free, emit, m_load;
    logic                    neg_w, neg_hx, neg_hy;
    logic signed [ACC_W-1:0] acc_x, acc_y;
    logic signed [27:0]      sh_x, sh_y;
    logic signed [25:0]      n_pos_x, n_pos_y;
    t_corner                 n_k;

    assign out_free = !r_o_vld || i_ready;
    assign emit     = r_m_vld && out_free;
    assign m_load   = !r_m_vld || (emit && r_k == CORNER_TL);
    assign o_hs.valid = i_q_valid;
    assign o_hs.pop   = m_load;
    assign o_valid  = r_o_vld;

    function automatic logic signed [25:0] sat_pos(input logic signed [27:0] v);
        if (v > POS_MAX) begin
            sat_pos = POS_MAX[25:0];
        end else if (v < POS_MIN) begin
            sat_pos = POS_MIN[25:0];
        end else begin
            sat_pos = v[25:0];
        end
    endfunction

    always_comb begin
        neg_w  = (r_k == CORNER_BL) || (r_k == CORNER_TL);
        neg_hx = (r_k == CORNER_TR) || (r_k == CORNER_TL);
        neg_hy = (r_k == CORNER_BL) || (r_k == CORNER_BR);
        acc_x  = r_bx + (neg_w  ? -ACC_W'(r_hwc) : ACC_W'(r_hwc))
                      + (neg_hx ? -ACC_W'(r_hhs) : ACC_W'(r_hhs));
        acc_y  = r_by + (neg_w  ? -ACC_W'(r_hws) : ACC_W'(r_hws))
                      + (neg_hy ? -ACC_W'(r_hhc) : ACC_W'(r_hhc));
        sh_x    = acc_x[ACC_W-1:25];
        sh_y    = acc_y[ACC_W-1:25];
        n_pos_x = sat_pos(sh_x);
        n_pos_y = sat_pos(sh_y);
        n_k     = t_corner'(r_k + 2'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_k     <= CORNER_BL;
            r_o_vld <= 1'b0;
        end else begin
            if (m_load) begin
                r_m_vld <= i_q_valid;
            end
            if (emit) begin
                r_k <= n_k;
            end
            if (out_free) begin
                r_o_vld <= emit;
            end
        end
    end

    // products and rounded centre, Q.33
    always_ff @(posedge i_clk) begin
        if (m_load) begin
            r_hwc  <= $signed({1'b0, i_q_data.spr.hw}) * i_q_data.cos_v;
            r_hhs  <= $signed({1'b0, i_q_data.spr.hh}) * i_q_data.sin_v;
            r_hws  <= $signed({1'b0, i_q_data.spr.hw}) * i_q_data.sin_v;
            r_hhc  <= $signed({1'b0, i_q_data.spr.hh}) * i_q_data.cos_v;
            r_bx   <= (ACC_W'(i_q_data.spr.cx) + ACC_W'(1)) <<< 24;
            r_by   <= (ACC_W'(i_q_data.spr.cy) + ACC_W'(1)) <<< 24;
            r_u0   <= i_q_data.spr.u0;
            r_u1   <= i_q_data.spr.u1;
            r_v0   <= i_q_data.spr.v0;
            r_v1   <= i_q_data.spr.v1;
            r_tint <= i_q_data.spr.tint;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_corner <= r_k;
            o_pos_x  <= n_pos_x;
            o_pos_y  <= n_pos_y;
            o_tex_u  <= neg_w ? r_u0 : r_u1;
            o_tex_v  <= neg_hy ? r_v1 : r_v0;
            o_tint   <= r_tint;
            o_last   <= (r_k == CORNER_TL);
        end
    end

endmodule

// ===== rtl/core/rsqb_checker.sv =====
// ----------------------------------------------------------------------------
// rsqb_checker
// Port-level checks on the vertex stream of the quad builder.
// ----------------------------------------------------------------------------
module rsqb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic [1:0]         o_corner,
    input logic signed [25:0] o_pos_x,
    input logic signed [25:0] o_pos_y,
    input logic [17:0]        o_tex_u,
    input logic [17:0]        o_tex_v,
    input logic [31:0]        o_tint,
    input logic               o_last
);
    import rsqb_pkg::*;

    a_rst_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_last_on_tl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_corner == CORNER_TL)))
        else $error("last flag does not match corner");

    // corners of one sprite come out back to back with one tint
    a_corner_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=>
            o_valid && (o_corner == ($past(o_corner) + 2'd1)) && $stable(o_tint))
        else $error("vertex sequence broken inside a sprite");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=>
            o_valid && $stable(o_corner) && $stable(o_pos_x) && $stable(o_pos_y)
            && $stable(o_tex_u) && $stable(o_tex_v) && $stable(o_tint))
        else $error("stalled vertex changed");

endmodule

bind rotated_sprite_quad_builder rsqb_checker u_rsqb_checker (.*);

// ===== tb/sv/rsqb_vertex_checker.sv =====
// ----------------------------------------------------------------------------
// rsqb_vertex_checker
// Watches the sprite and vertex channels of the quad builder. Each accepted
// sprite is expanded into its four expected vertices. The expansion uses a
// bit-accurate CORDIC, rounding and saturation. Each vertex transfer is
// compared, field by field, with the oldest expected vertex.
// ----------------------------------------------------------------------------
module rsqb_vertex_checker #(
    parameter int CORDIC_STAGES = rsqb_pkg::CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [23:0]        i_dst_x,
    input  logic [23:0]        i_dst_y,
    input  logic [23:0]        i_dst_w,
    input  logic [23:0]        i_dst_h,
    input  logic [16:0]        i_src_u,
    input  logic [16:0]        i_src_v,
    input  logic [16:0]        i_src_w,
    input  logic [16:0]        i_src_h,
    input  logic [15:0]        i_angle,
    input  logic [31:0]        i_color_rgba,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [1:0]         i_corner,
    input  logic signed [25:0] i_pos_x,
    input  logic signed [25:0] i_pos_y,
    input  logic [17:0]        i_tex_u,
    input  logic [17:0]        i_tex_v,
    input  logic [31:0]        i_tint,
    input  logic               i_last,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_vertex_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     STAGES_USED = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
    localparam longint GAIN_Q24    = 64'sd10188014;
    localparam longint POS_HI      = 64'sd33554431;
    localparam longint POS_LO      = -64'sd33554432;

    // atan(2^-i) in 2^-32 turn units
    localparam longint ARCTAN_TURNS [24] = '{
        64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
        64'sd42667331,  64'sd21354465,  64'sd10679838,  64'sd5340245,
        64'sd2670163,   64'sd1335087,   64'sd667544,    64'sd333772,
        64'sd166886,    64'sd83443,     64'sd41722,     64'sd20861,
        64'sd10430,     64'sd5215,      64'sd2608,      64'sd1304,
        64'sd652,       64'sd326,       64'sd163,       64'sd81
    };

    typedef struct {
        rsqb_pkg::t_corner  corner;
        logic signed [25:0] pos_x;
        logic signed [25:0] pos_y;
        logic [17:0]        tex_u;
        logic [17:0]        tex_v;
        logic [31:0]        tint;
        logic               last;
    } t_vertex;

    t_vertex expected_vertices[$];
    int      fail_count   = 0;
    int      pending      = 0;
    int      vertex_count = 0;

    assign o_fail_count   = fail_count;
    assign o_pending      = pending;
    assign o_vertex_count = vertex_count;

    // quadrant fold, then CORDIC rotation of (gain, 0) by the residual angle
    function automatic void rotation(input logic [15:0] ang, output longint c,
                                     output longint s);
        int     q;
        longint r, x, y, z, t, dx, dy;
        q = ((int'(ang) + 'h2000) >> 14) & 3;
        r = longint'(ang) - longint'(q) * 64'sd16384;
        if (r >= 64'sd32768) r = r - 64'sd65536;
        z = r * 64'sd65536;
        x = GAIN_Q24;
        y = 0;
        for (int i = 0; i < STAGES_USED; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_TURNS[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_TURNS[i];
            end
        end
        case (q)
            1: begin
                t = x;
                x = -y;
                y = t;
            end
            2: begin
                x = -x;
                y = -y;
            end
            3: begin
                t = x;
                x = y;
                y = -t;
            end
            default: ;
        endcase
        c = x;
        s = y;
    endfunction

    // Q.33 to Q.8, halves toward plus infinity, then clamp to 26 bits
    function automatic logic signed [25:0] round_sat(input longint acc);
        longint v;
        v = (acc + 64'sd16777216) >>> 25;
        if (v > POS_HI) v = POS_HI;
        else if (v < POS_LO) v = POS_LO;
        return v[25:0];
    endfunction

    task automatic predict_quad();
        longint      cx, cy, hw, hh, c, s, lx, ly;
        logic [17:0] u0, u1, v0, v1;
        t_vertex     vx;
        rotation(i_angle, c, s);
        hw = longint'(i_dst_w);
        hh = longint'(i_dst_h);
        cx = 2 * longint'(signed'(i_dst_x)) + hw;
        cy = 2 * longint'(signed'(i_dst_y)) + hh;
        u0 = {1'b0, i_src_u};
        v0 = {1'b0, i_src_v};
        u1 = u0 + {1'b0, i_src_w};
        v1 = v0 + {1'b0, i_src_h};
        for (int k = 0; k < 4; k++) begin
            lx = (k == 0 || k == 3) ? -hw : hw;
            ly = (k < 2) ? -hh : hh;
            vx.corner = rsqb_pkg::t_corner'(k);
            vx.pos_x  = round_sat(cx * 64'sd16777216 + (lx * c - ly * s));
            vx.pos_y  = round_sat(cy * 64'sd16777216 + (lx * s + ly * c));
            vx.tex_u  = (k == 0 || k == 3) ? u0 : u1;
            vx.tex_v  = (k < 2) ? v1 : v0;
            vx.tint   = i_color_rgba;
            vx.last   = (k == 3);
            expected_vertices = {expected_vertices, vx};
        end
    endtask

    function automatic int field_diff(input string name, input longint want,
                                      input longint got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_vertex exp_v;
        int      bad;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) predict_quad();
            if (i_out_valid && i_out_ready) begin
                vertex_count++;
                if (expected_vertices.size() == 0) begin
                    $display("%0t ns: unexpected vertex transfer, corner %0d pos (%0d, %0d)",
                             $time, i_corner, i_pos_x, i_pos_y);
                    fail_count++;
                end else begin
                    exp_v = expected_vertices.pop_front();
                    bad = 0;
                    bad += field_diff("corner", exp_v.corner, i_corner);
                    bad += field_diff("pos_x", exp_v.pos_x, i_pos_x);
                    bad += field_diff("pos_y", exp_v.pos_y, i_pos_y);
                    bad += field_diff("tex_u", exp_v.tex_u, i_tex_u);
                    bad += field_diff("tex_v", exp_v.tex_v, i_tex_v);
                    bad += field_diff("tint", exp_v.tint, i_tint);
                    bad += field_diff("last", exp_v.last, i_last);
                    if (bad != 0) fail_count++;
                end
            end
        end
        pending = expected_vertices.size();
    end

endmodule

// ===== tb/sv/tb_rotated_sprite_quad_builder.sv =====
// ----------------------------------------------------------------------------
// tb_rotated_sprite_quad_builder
// Stimulus and verdict for the rotated sprite quad builder. A directed set
// covers extreme rectangles, quadrant-fold angles, full UV sums and collapsed
// extents. Random sprites follow, under three sender/receiver idle mixes and
// one long output hold-off. Checking is done in rsqb_vertex_checker.
// ----------------------------------------------------------------------------
module tb_rotated_sprite_quad_builder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES           = rsqb_pkg::CORDIC_STAGES_DEF;
    localparam int RANDOM_PER_PHASE = 120;
    localparam int HOLD_CYCLES      = 400;
    localparam int TX_IDLE [3]      = '{21, 61, 0};
    localparam int RX_IDLE [3]      = '{61, 21, 0};

    typedef struct {
        logic [23:0] dst_x;
        logic [23:0] dst_y;
        logic [23:0] dst_w;
        logic [23:0] dst_h;
        logic [16:0] src_u;
        logic [16:0] src_v;
        logic [16:0] src_w;
        logic [16:0] src_h;
        logic [15:0] angle;
        logic [31:0] color;
    } t_sprite_in;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [23:0]        i_dst_x;
    logic [23:0]        i_dst_y;
    logic [23:0]        i_dst_w;
    logic [23:0]        i_dst_h;
    logic [16:0]        i_src_u;
    logic [16:0]        i_src_v;
    logic [16:0]        i_src_w;
    logic [16:0]        i_src_h;
    logic [15:0]        i_angle;
    logic [31:0]        i_color_rgba;
    logic               o_valid;
    logic               i_ready;
    logic [1:0]         o_corner;
    logic signed [25:0] o_pos_x;
    logic signed [25:0] o_pos_y;
    logic [17:0]        o_tex_u;
    logic [17:0]        o_tex_v;
    logic [31:0]        o_tint;
    logic               o_last;

    int         fail_count;
    int         pending;
    int         vertex_count;
    int         sent_count  = 0;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    logic       hold_output = 1'b0;
    t_sprite_in directed_sprites[$];

    rotated_sprite_quad_builder #(
        .CORDIC_STAGES(STAGES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_dst_x     (i_dst_x),
        .i_dst_y     (i_dst_y),
        .i_dst_w     (i_dst_w),
        .i_dst_h     (i_dst_h),
        .i_src_u     (i_src_u),
        .i_src_v     (i_src_v),
        .i_src_w     (i_src_w),
        .i_src_h     (i_src_h),
        .i_angle     (i_angle),
        .i_color_rgba(i_color_rgba),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_corner    (o_corner),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_tex_u     (o_tex_u),
        .o_tex_v     (o_tex_v),
        .o_tint      (o_tint),
        .o_last      (o_last)
    );

    rsqb_vertex_checker #(
        .CORDIC_STAGES(STAGES)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_dst_x       (i_dst_x),
        .i_dst_y       (i_dst_y),
        .i_dst_w       (i_dst_w),
        .i_dst_h       (i_dst_h),
        .i_src_u       (i_src_u),
        .i_src_v       (i_src_v),
        .i_src_w       (i_src_w),
        .i_src_h       (i_src_h),
        .i_angle       (i_angle),
        .i_color_rgba  (i_color_rgba),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_corner      (o_corner),
        .i_pos_x       (o_pos_x),
        .i_pos_y       (o_pos_y),
        .i_tex_u       (o_tex_u),
        .i_tex_v       (o_tex_v),
        .i_tint        (o_tint),
        .i_last        (o_last),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_vertex_count(vertex_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("rotated_sprite_quad_builder verification failed");
        $finish;
    end

    function automatic t_sprite_in mk_sprite(
        input logic [23:0] x, input logic [23:0] y,
        input logic [23:0] w, input logic [23:0] h,
        input logic [16:0] u, input logic [16:0] v,
        input logic [16:0] sw, input logic [16:0] sh,
        input logic [15:0] ang, input logic [31:0] col);
        t_sprite_in s;
        s.dst_x = x;
        s.dst_y = y;
        s.dst_w = w;
        s.dst_h = h;
        s.src_u = u;
        s.src_v = v;
        s.src_w = sw;
        s.src_h = sh;
        s.angle = ang;
        s.color = col;
        return s;
    endfunction

    function automatic void add_directed(input t_sprite_in s);
        directed_sprites = {directed_sprites, s};
    endfunction

    // a quadrant fold point, or one off either side of it
    function automatic logic [15:0] fold_angle();
        return 16'($urandom_range(0, 3) * 'h4000 + 'h2000 + $urandom_range(0, 2) - 1);
    endfunction

    function automatic t_sprite_in random_sprite();
        t_sprite_in s;
        int         mode;
        mode = $urandom_range(0, 9);
        s = mk_sprite(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                      17'($urandom), 17'($urandom), 17'($urandom), 17'($urandom),
                      16'($urandom), $urandom);
        if (mode < 6) begin
            // typical on-screen sprite
            s.dst_x = 24'($urandom_range(0, 'h1FFFFF)) - 24'h100000;
            s.dst_y = 24'($urandom_range(0, 'h1FFFFF)) - 24'h100000;
            s.dst_w = 24'($urandom_range(0, 'h3FFFF));
            s.dst_h = 24'($urandom_range(0, 'h3FFFF));
            s.src_u = 17'($urandom_range(0, 'hFFFF));
            s.src_v = 17'($urandom_range(0, 'hFFFF));
            s.src_w = 17'($urandom_range(0, 'hFFFF));
            s.src_h = 17'($urandom_range(0, 'hFFFF));
            if ($urandom_range(0, 9) == 0) s.angle = fold_angle();
        end else if (mode == 8) begin
            s.dst_x = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            s.dst_y = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            s.dst_w = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
            s.dst_h = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
            s.src_u = $urandom_range(0, 1) ? 17'h1FFFF : 17'h00000;
            s.src_v = $urandom_range(0, 1) ? 17'h1FFFF : 17'h00000;
            s.src_w = $urandom_range(0, 1) ? 17'h1FFFF : 17'h00000;
            s.src_h = $urandom_range(0, 1) ? 17'h1FFFF : 17'h00000;
            s.angle = fold_angle();
        end else if (mode == 9) begin
            s.dst_w = '0;
            s.dst_h = '0;
            s.angle = fold_angle();
        end
        return s;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_sprite(input t_sprite_in s);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_dst_x      <= s.dst_x;
        i_dst_y      <= s.dst_y;
        i_dst_w      <= s.dst_w;
        i_dst_h      <= s.dst_h;
        i_src_u      <= s.src_u;
        i_src_v      <= s.src_v;
        i_src_w      <= s.src_w;
        i_src_h      <= s.src_h;
        i_angle      <= s.angle;
        i_color_rgba <= s.color;
        i_valid      <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        sent_count++;
    endtask

    task automatic drain_vertices();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_ready <= !hold_output && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // long output stall in the no-idle phase so the block backs up to its input
    initial begin
        do @(posedge i_clk);
        while (sent_count < directed_sprites.size() + 2 * RANDOM_PER_PHASE + 20);
        hold_output = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_output = 1'b0;
    end

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_dst_x      = '0;
        i_dst_y      = '0;
        i_dst_w      = '0;
        i_dst_h      = '0;
        i_src_u      = '0;
        i_src_v      = '0;
        i_src_w      = '0;
        i_src_h      = '0;
        i_angle      = '0;
        i_color_rgba = '0;

        add_directed(mk_sprite(24'h0, 24'h0, 24'h0, 24'h0,
            17'h0, 17'h0, 17'h0, 17'h0, 16'h0000, 32'h0));
        add_directed(mk_sprite(24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF,
            17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 16'h0000, 32'hFFFFFFFF));
        add_directed(mk_sprite(24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF,
            17'h0, 17'h0, 17'h0, 17'h0, 16'h2000, 32'h11223344));
        add_directed(mk_sprite(24'h800000, 24'h800000, 24'hFFFFFF, 24'hFFFFFF,
            17'h0, 17'h0, 17'h1FFFF, 17'h1FFFF, 16'hA000, 32'h80808080));
        add_directed(mk_sprite(24'h800000, 24'h800000, 24'h0, 24'h0,
            17'h0, 17'h0, 17'h0, 17'h0, 16'h8000, 32'h00000001));
        // collapsed rectangle: all corners on the centre
        add_directed(mk_sprite(24'h012345, 24'hFEDCBA, 24'h0, 24'h0,
            17'h04000, 17'h08000, 17'h01000, 17'h02000, 16'h1234, 32'hDEADBEEF));
        add_directed(mk_sprite(24'h001000, 24'h002000, 24'h004000, 24'h002000,
            17'h0, 17'h0, 17'h10000, 17'h10000, 16'h1FFF, 32'h01020304));
        add_directed(mk_sprite(24'h001000, 24'h002000, 24'h004000, 24'h002000,
            17'h0, 17'h0, 17'h10000, 17'h10000, 16'h2000, 32'h01020304));
        add_directed(mk_sprite(24'h001000, 24'h002000, 24'h004000, 24'h002000,
            17'h0, 17'h0, 17'h10000, 17'h10000, 16'h4000, 32'h01020304));
        add_directed(mk_sprite(24'h001000, 24'h002000, 24'h004000, 24'h002000,
            17'h0, 17'h0, 17'h10000, 17'h10000, 16'h5FFF, 32'h01020304));
        add_directed(mk_sprite(24'h001000, 24'h002000, 24'h004000, 24'h002000,
            17'h0, 17'h0, 17'h10000, 17'h10000, 16'h6000, 32'h01020304));
        add_directed(mk_sprite(24'h001000, 24'h002000, 24'h004000, 24'h002000,
            17'h0, 17'h0, 17'h10000, 17'h10000, 16'h8000, 32'h01020304));
        add_directed(mk_sprite(24'h001000, 24'h002000, 24'h004000, 24'h002000,
            17'h0, 17'h0, 17'h10000, 17'h10000, 16'hC000, 32'h01020304));
        add_directed(mk_sprite(24'h001000, 24'h002000, 24'h004000, 24'h002000,
            17'h0, 17'h0, 17'h10000, 17'h10000, 16'hDFFF, 32'h01020304));
        add_directed(mk_sprite(24'h001000, 24'h002000, 24'h004000, 24'h002000,
            17'h0, 17'h0, 17'h10000, 17'h10000, 16'hE000, 32'h01020304));
        add_directed(mk_sprite(24'h001000, 24'h002000, 24'h004000, 24'h002000,
            17'h0, 17'h0, 17'h10000, 17'h10000, 16'hFFFF, 32'h01020304));
        // largest UV sums
        add_directed(mk_sprite(24'hFFF000, 24'h000800, 24'h000300, 24'h000500,
            17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 16'h0100, 32'hA5A5A5A5));
        add_directed(mk_sprite(24'h000800, 24'hFFF000, 24'h000500, 24'h000300,
            17'h0, 17'h0, 17'h0, 17'h0, 16'hF000, 32'h5A5A5A5A));
        add_directed(mk_sprite(24'h000000, 24'h000000, 24'h000001, 24'hFFFFFF,
            17'h00001, 17'h10000, 17'h0FFFF, 17'h00001, 16'h4000, 32'hFF000000));
        add_directed(mk_sprite(24'h7FFFFF, 24'h800000, 24'hFFFFFF, 24'h000001,
            17'h0AAAA, 17'h15555, 17'h15555, 17'h0AAAA, 16'h2001, 32'h000000FF));
        add_directed(mk_sprite(24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555,
            17'h15555, 17'h0AAAA, 17'h0AAAA, 17'h15555, 16'hAAAA, 32'h0F0F0F0F));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_sprites[i]) send_sprite(directed_sprites[i]);
        drain_vertices();

        for (int ph = 0; ph < 3; ph++) begin
            @(posedge i_clk);
            tx_idle_pct = TX_IDLE[ph];
            rx_idle_pct = RX_IDLE[ph];
            @(negedge i_clk);
            repeat (RANDOM_PER_PHASE) send_sprite(random_sprite());
            drain_vertices();
        end

        repeat (STAGES + 20) @(negedge i_clk);

        $display("covered %0d sprites (%0d directed) under three idle mixes and a %0d-cycle hold",
                 sent_count, directed_sprites.size(), HOLD_CYCLES);
        $display("%0d vertices compared, %0d mismatching", vertex_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("rotated_sprite_quad_builder verification clean");
        end else begin
            $display("rotated_sprite_quad_builder verification failed");
        end
        $finish;
    end

endmodule
